// ===== src/c25_pkg.sv =====
// Shared types, constants and tables of the GF(2^255-19) arithmetic unit.
// Used by c25_mul, c25_cols, c25_store, the top level and the bench; depends on nothing.
package c25_pkg;

	localparam int NUM_LIMBS   = 5;
	localparam int LIMB_BITS   = 51;
	localparam int LIMB_W      = 52;
	localparam int HALF_W      = 26;
	localparam int PROD_W      = 2 * HALF_W;
	localparam int NUM_COLS    = 9;
	localparam int COL_W       = 116;
	localparam int SLOT_W      = 3;
	localparam int ADDR_W      = 6;
	localparam int STORE_DEPTH = 40;
	localparam int PC_W        = 4;
	localparam int NSQ_W       = 7;
	localparam int FS_W        = 5;
	localparam int IN_TDATA_W  = 2 * NUM_LIMBS * LIMB_W;
	localparam int OUT_TDATA_W = 264;

	localparam logic [PC_W-1:0] PROG_LAST = 4'd12;
	localparam logic [FS_W-1:0] FOLD_LAST = 5'd20;

	typedef logic [LIMB_W-1:0] limb_t;
	typedef logic [COL_W-1:0]  col_t;

	localparam col_t LOW_MASK = col_t'({LIMB_BITS{1'b1}});

	// opcodes
	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_SQR = 2'd1;
	localparam logic [1:0] OP_INV = 2'd2;

	// column unit operations
	localparam logic [2:0] COL_NOP   = 3'd0;
	localparam logic [2:0] COL_CLEAR = 3'd1;
	localparam logic [2:0] COL_ACC   = 3'd2;
	localparam logic [2:0] COL_CARRY = 3'd3;
	localparam logic [2:0] COL_FOLD  = 3'd4;
	localparam logic [2:0] COL_WRAP  = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] idx;
	} col_ctrl_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] col;
		logic [1:0] shift;
	} mul_tag_t;

	typedef struct packed {
		logic [NSQ_W-1:0]  nsq;
		logic              has_mul;
		logic [SLOT_W-1:0] mul_slot;
		logic              has_save;
		logic [SLOT_W-1:0] save_slot;
	} prog_t;

	// Inversion chain: square nsq times, optionally multiply by a slot,
	// optionally save the working value into a slot.
	function automatic prog_t prog_entry(input logic [PC_W-1:0] pc);
		prog_t e;
		e = '0;
		unique case (pc)
			4'd0:  e = '{7'd0,   1'b0, 3'd0, 1'b1, 3'd0};
			4'd1:  e = '{7'd1,   1'b0, 3'd0, 1'b1, 3'd1};
			4'd2:  e = '{7'd2,   1'b1, 3'd0, 1'b1, 3'd2};
			4'd3:  e = '{7'd0,   1'b1, 3'd1, 1'b1, 3'd3};
			4'd4:  e = '{7'd1,   1'b1, 3'd2, 1'b1, 3'd4};
			4'd5:  e = '{7'd5,   1'b1, 3'd4, 1'b1, 3'd5};
			4'd6:  e = '{7'd10,  1'b1, 3'd5, 1'b1, 3'd6};
			4'd7:  e = '{7'd20,  1'b1, 3'd6, 1'b0, 3'd0};
			4'd8:  e = '{7'd10,  1'b1, 3'd5, 1'b1, 3'd7};
			4'd9:  e = '{7'd50,  1'b1, 3'd7, 1'b1, 3'd6};
			4'd10: e = '{7'd100, 1'b1, 3'd6, 1'b0, 3'd0};
			4'd11: e = '{7'd50,  1'b1, 3'd7, 1'b0, 3'd0};
			4'd12: e = '{7'd5,   1'b1, 3'd3, 1'b0, 3'd0};
			default: e = '0;
		endcase
		return e;
	endfunction

	// Reduction sequence: carry over all columns, fold the upper columns by 19,
	// carry, wrap the top limb by 19, carry again.
	function automatic col_ctrl_t fold_step(input logic [FS_W-1:0] fs);
		col_ctrl_t c;
		c.op  = COL_CARRY;
		c.idx = 4'(fs);
		priority if (fs < 5'd8) begin
			c.op  = COL_CARRY;
			c.idx = 4'(fs);
		end else if (fs < 5'd12) begin
			c.op  = COL_FOLD;
			c.idx = 4'(fs - 5'd8);
		end else if (fs < 5'd16) begin
			c.op  = COL_CARRY;
			c.idx = 4'(fs - 5'd12);
		end else if (fs == 5'd16) begin
			c.op  = COL_WRAP;
			c.idx = 4'd0;
		end else begin
			c.op  = COL_CARRY;
			c.idx = 4'(fs - 5'd17);
		end
		return c;
	endfunction

	// x * 19 as shift-adds
	function automatic col_t times19(input col_t x);
		return (x << 4) + (x << 1) + x;
	endfunction

endpackage

// ===== src/c25_mul.sv =====
// Shared 26x26 multiplier with a registered product and tag.
// Depends on c25_pkg.
module c25_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  c25_pkg::mul_tag_t             tag_in,
	input  logic [c25_pkg::HALF_W-1:0]    x,
	input  logic [c25_pkg::HALF_W-1:0]    y,
	output logic [c25_pkg::PROD_W-1:0]    prod_s1,
	output c25_pkg::mul_tag_t             tag_s1
);
	import c25_pkg::*;

	logic [PROD_W-1:0] prod_c;

	assign prod_c = x * y;

	// tag carries the valid flag and the column target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
	end

endmodule

// ===== src/c25_cols.sv =====
// Column accumulators: accumulate partial products, then carry and fold by 19.
// Depends on c25_pkg.
module c25_cols (
	input  logic                       clk,
	input  c25_pkg::col_ctrl_t         ctrl,
	input  c25_pkg::mul_tag_t          tag,
	input  logic [c25_pkg::PROD_W-1:0] prod,
	output c25_pkg::limb_t             res [c25_pkg::NUM_LIMBS]
);
	import c25_pkg::*;

	col_t       col_q   [NUM_COLS];
	col_t       carry_in[NUM_COLS];
	col_t       fold_in [NUM_COLS];
	col_t       wrap_in;
	col_t       acc_val;
	logic [2:0] op;
	logic [3:0] idx;

	// a product in flight takes priority over sequencer steps
	always_comb begin
		if (tag.valid) begin
			op  = COL_ACC;
			idx = tag.col;
		end else begin
			op  = ctrl.op;
			idx = ctrl.idx;
		end
	end

	always_comb begin
		unique case (tag.shift)
			2'd0:    acc_val = col_t'(prod);
			2'd1:    acc_val = col_t'(prod) << HALF_W;
			2'd2:    acc_val = col_t'(prod) << (2 * HALF_W);
			default: acc_val = '0;
		endcase
	end

	assign wrap_in = times19(col_q[4] >> LIMB_BITS);

	for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
		col_t add_c;
		logic msk_c;

		if (c > 0) begin : g_cin
			assign carry_in[c] = col_q[c-1] >> LIMB_BITS;
		end else begin : g_cin0
			assign carry_in[c] = '0;
		end

		if (c < 4) begin : g_fin
			assign fold_in[c] = times19(col_q[c+5]);
		end else begin : g_fin0
			assign fold_in[c] = '0;
		end

		// one addend per column, picked by the operation
		always_comb begin
			add_c = '0;
			msk_c = 1'b0;
			unique case (op)
				COL_ACC: begin
					if (idx == 4'(c)) add_c = acc_val;
				end
				COL_CARRY: begin
					if (idx == 4'(c)) msk_c = 1'b1;
					else if (idx == 4'(c - 1)) add_c = carry_in[c];
				end
				COL_FOLD: begin
					if (idx == 4'(c)) add_c = fold_in[c];
				end
				COL_WRAP: begin
					if (c == 0) add_c = wrap_in;
					if (c == 4) msk_c = 1'b1;
				end
				default: ;
			endcase
		end

		always_ff @(posedge clk) begin
			if (op == COL_CLEAR) begin
				col_q[c] <= '0;
			end else if (msk_c) begin
				col_q[c] <= col_q[c] & LOW_MASK;
			end else begin
				col_q[c] <= col_q[c] + add_c;
			end
		end
	end

	for (genvar l = 0; l < NUM_LIMBS; l++) begin : g_res
		assign res[l] = col_q[l][LIMB_W-1:0];
	end

endmodule

// ===== src/c25_store.sv =====
// Store of the inversion intermediates: eight slots of five limbs.
// Depends on c25_pkg.
module c25_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [c25_pkg::ADDR_W-1:0] waddr,
	input  c25_pkg::limb_t             wdata,
	input  logic [c25_pkg::ADDR_W-1:0] raddr,
	output c25_pkg::limb_t             rdata
);
	import c25_pkg::*;

	limb_t mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== src/curve25519_field_mul_sqr_inv.sv =====
// Multiply, square and invert over GF(2^255-19) in radix 2^51; one result per input.
// A multiply or square runs the single 26x26 multiplier, which forms the 100 partial
// products of a 5x5 limb product (one per cycle), then a 21-step carry/fold pass.
// Invert runs the fixed chain of 254 squarings and 11 multiplies through the same
// unit. The input is taken only while the sequencer is idle; a finished result
// waits in the output register and the next transaction may be accepted meanwhile.
// Opcode 3 returns zero.
module curve25519_field_mul_sqr_inv (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// a_limb0..a_limb4, b_limb0..b_limb4, 52 bits each
	input  logic [c25_pkg::IN_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// r_limb0..r_limb4, 52 bits each, then zero pad
	output logic [c25_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import c25_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_DRAIN = 4'd3;
	localparam logic [3:0] S_FOLD  = 4'd4;
	localparam logic [3:0] S_WB    = 4'd5;
	localparam logic [3:0] S_ENTRY = 4'd6;
	localparam logic [3:0] S_SQ    = 4'd7;
	localparam logic [3:0] S_LDB   = 4'd8;
	localparam logic [3:0] S_SAVE  = 4'd9;
	localparam logic [3:0] S_NEXT  = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0]        state_q;
	logic [2:0]        i_q, j_q, k_q;
	logic [1:0]        h_q;
	logic [FS_W-1:0]   fs_q;
	logic [PC_W-1:0]   pc_q;
	logic [NSQ_W-1:0]  sq_left_q;
	logic              inv_q;
	logic              phase_q;
	logic              m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	limb_t opa_q [NUM_LIMBS];
	limb_t opb_q [NUM_LIMBS];
	limb_t wv_q  [NUM_LIMBS];
	limb_t in_a  [NUM_LIMBS];
	limb_t in_b  [NUM_LIMBS];
	limb_t res   [NUM_LIMBS];

	prog_t             ent;
	logic [3:0]        post_sq_state;
	mul_tag_t          tag_in, tag_s1;
	logic [HALF_W-1:0] mx, my;
	logic [PROD_W-1:0] prod_s1;
	col_ctrl_t         ctrl;
	logic              st_we;
	logic [ADDR_W-1:0] st_waddr, st_raddr;
	logic [2:0]        rd_k;
	limb_t             st_rdata;
	logic              out_free;

	for (genvar l = 0; l < NUM_LIMBS; l++) begin : g_in
		assign in_a[l] = s_tdata[LIMB_W*l +: LIMB_W];
		assign in_b[l] = s_tdata[LIMB_W*(NUM_LIMBS+l) +: LIMB_W];
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign ent = prog_entry(pc_q);

	// what follows the squarings of a chain entry
	always_comb begin
		priority if (ent.has_mul) post_sq_state = S_LDB;
		else if (ent.has_save) post_sq_state = S_SAVE;
		else post_sq_state = S_NEXT;
	end

	// partial product issue
	assign mx = h_q[0] ? opa_q[i_q][LIMB_W-1:HALF_W] : opa_q[i_q][HALF_W-1:0];
	assign my = h_q[1] ? opb_q[j_q][LIMB_W-1:HALF_W] : opb_q[j_q][HALF_W-1:0];
	assign tag_in.valid = (state_q == S_MUL);
	assign tag_in.col   = {1'b0, i_q} + {1'b0, j_q};
	assign tag_in.shift = {1'b0, h_q[0]} + {1'b0, h_q[1]};

	always_comb begin
		unique case (state_q)
			S_CLR:   ctrl = '{COL_CLEAR, 4'd0};
			S_FOLD:  ctrl = fold_step(fs_q);
			default: ctrl = '{COL_NOP, 4'd0};
		endcase
	end

	// store addressing: slot * 5 + limb
	assign rd_k     = (k_q > 3'd4) ? 3'd4 : k_q;
	assign st_we    = (state_q == S_SAVE);
	assign st_waddr = ADDR_W'({ent.save_slot, 2'b00}) + ADDR_W'(ent.save_slot)
		+ ADDR_W'(k_q);
	assign st_raddr = ADDR_W'({ent.mul_slot, 2'b00}) + ADDR_W'(ent.mul_slot)
		+ ADDR_W'(rd_k);

	c25_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_in),
		.x       (mx),
		.y       (my),
		.prod_s1 (prod_s1),
		.tag_s1  (tag_s1)
	);

	c25_cols u_cols (
		.clk  (clk),
		.ctrl (ctrl),
		.tag  (tag_s1),
		.prod (prod_s1),
		.res  (res)
	);

	c25_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (wv_q[k_q]),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			h_q        <= '0;
			k_q        <= '0;
			fs_q       <= '0;
			pc_q       <= '0;
			sq_left_q  <= '0;
			inv_q      <= 1'b0;
			phase_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// S_FIN sets the flag itself when the output register is free
			if (m_tvalid_q && m_tready && state_q != S_FIN) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						unique case (s_tuser)
							OP_MUL, OP_SQR: begin
								inv_q   <= 1'b0;
								state_q <= S_CLR;
							end
							OP_INV: begin
								inv_q   <= 1'b1;
								pc_q    <= '0;
								state_q <= S_ENTRY;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_CLR: begin
					i_q     <= '0;
					j_q     <= '0;
					h_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					h_q <= h_q + 2'd1;
					if (h_q == 2'd3) begin
						if (j_q == 3'd4) begin
							j_q <= '0;
							if (i_q == 3'd4) state_q <= S_DRAIN;
							else i_q <= i_q + 3'd1;
						end else begin
							j_q <= j_q + 3'd1;
						end
					end
				end
				S_DRAIN: begin
					fs_q    <= '0;
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (fs_q == FOLD_LAST) state_q <= S_WB;
					else fs_q <= fs_q + 5'd1;
				end
				S_WB: begin
					k_q <= '0;
					priority if (!inv_q) state_q <= S_FIN;
					else if (phase_q) state_q <= ent.has_save ? S_SAVE : S_NEXT;
					else if (sq_left_q != '0) state_q <= S_SQ;
					else state_q <= post_sq_state;
				end
				S_ENTRY: begin
					k_q       <= '0;
					sq_left_q <= ent.nsq;
					if (ent.nsq != '0) state_q <= S_SQ;
					else state_q <= post_sq_state;
				end
				S_SQ: begin
					sq_left_q <= sq_left_q - 7'd1;
					phase_q   <= 1'b0;
					state_q   <= S_CLR;
				end
				S_LDB: begin
					if (k_q == 3'd5) begin
						phase_q <= 1'b1;
						state_q <= S_CLR;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_SAVE: begin
					if (k_q == 3'd4) state_q <= S_NEXT;
					else k_q <= k_q + 3'd1;
				end
				S_NEXT: begin
					if (pc_q == PROG_LAST) begin
						state_q <= S_FIN;
					end else begin
						pc_q    <= pc_q + 4'd1;
						state_q <= S_ENTRY;
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operand, working value and output registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					for (int l = 0; l < NUM_LIMBS; l++) begin
						opa_q[l] <= in_a[l];
						opb_q[l] <= (s_tuser == OP_MUL) ? in_b[l] : in_a[l];
						if (s_tuser == OP_INV) wv_q[l] <= in_a[l];
						else if (s_tuser != OP_MUL && s_tuser != OP_SQR) wv_q[l] <= '0;
					end
				end
			end
			S_WB: begin
				for (int l = 0; l < NUM_LIMBS; l++) wv_q[l] <= res[l];
			end
			S_SQ: begin
				for (int l = 0; l < NUM_LIMBS; l++) begin
					opa_q[l] <= wv_q[l];
					opb_q[l] <= wv_q[l];
				end
			end
			S_LDB: begin
				if (k_q == 3'd0) begin
					for (int l = 0; l < NUM_LIMBS; l++) opa_q[l] <= wv_q[l];
				end else begin
					opb_q[k_q - 3'd1] <= st_rdata;
				end
			end
			S_FIN: begin
				if (out_free) begin
					m_tdata_q <= {{(OUT_TDATA_W - NUM_LIMBS*LIMB_W){1'b0}},
						wv_q[4], wv_q[3], wv_q[2], wv_q[1], wv_q[0]};
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== bench/tb_curve25519_field_mul_sqr_inv.sv =====
// Self-checking bench for curve25519_field_mul_sqr_inv: multiply, square, invert mod 2^255-19.
// Depends on c25_pkg and the top level; carries its own radix 2^51 field predictor.
module tb_curve25519_field_mul_sqr_inv;
	import c25_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, returns zero
	localparam int         MAX_INV = 8;      // inverts in the random part
	localparam int         N_RAND  = 405;
	localparam int         QUIET_N = 40;     // last transactions run without idling

	typedef limb_t [NUM_LIMBS-1:0] fe_t;
	typedef logic [127:0]          wcol_t;
	typedef struct packed {
		logic [1:0] op;
		fe_t        a;
		fe_t        b;
	} fop_t;

	localparam wcol_t MASK51 = (wcol_t'(1) << LIMB_BITS) - 1;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [1:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	fop_t pending_ops[$];
	fe_t  expected_prods[$];
	fop_t cur_op;
	int   total_ops;
	int   sent_ops;
	int   got_results;
	int   err_count;
	int   src_gap;
	int   snk_gap;
	bit   long_hold_done;

	curve25519_field_mul_sqr_inv i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Exact column product, fold by 19, carry passes -> weakly reduced limbs.
	// Square is the same product with y = x: the doubled cross terms sum identically.
	function automatic fe_t field_mul(input fe_t x, input fe_t y);
		wcol_t d[9];
		wcol_t o[5];
		fe_t   r;
		for (int i = 0; i < 9; i++) d[i] = '0;
		for (int i = 0; i < NUM_LIMBS; i++)
			for (int j = 0; j < NUM_LIMBS; j++)
				d[i+j] += wcol_t'(x[i]) * wcol_t'(y[j]);
		for (int i = 0; i < 8; i++) begin
			d[i+1] += d[i] >> LIMB_BITS;
			d[i] &= MASK51;
		end
		for (int i = 0; i < 4; i++) o[i] = d[i] + d[i+5] * 19;
		o[4] = d[4];
		for (int i = 0; i < 4; i++) begin
			o[i+1] += o[i] >> LIMB_BITS;
			o[i] &= MASK51;
		end
		o[0] += (o[4] >> LIMB_BITS) * 19;
		o[4] &= MASK51;
		for (int i = 0; i < 4; i++) begin
			o[i+1] += o[i] >> LIMB_BITS;
			o[i] &= MASK51;
		end
		for (int i = 0; i < NUM_LIMBS; i++) r[i] = o[i][LIMB_W-1:0];
		return r;
	endfunction

	// square n times, then multiply by m
	function automatic fe_t sq_run_mul(input fe_t w, input int n, input fe_t m);
		fe_t v;
		v = w;
		for (int i = 0; i < n; i++) v = field_mul(v, v);
		return field_mul(v, m);
	endfunction

	// a^(p-2) by the standard 254-square / 11-multiply chain
	function automatic fe_t field_inv(input fe_t a);
		fe_t z2, z9, z11, t5, t10, t20, t50, t100, w;
		z2   = field_mul(a, a);
		z9   = sq_run_mul(z2, 2, a);
		z11  = field_mul(z9, z2);
		t5   = sq_run_mul(z11, 1, z9);
		t10  = sq_run_mul(t5, 5, t5);
		t20  = sq_run_mul(t10, 10, t10);
		w    = sq_run_mul(t20, 20, t20);
		t50  = sq_run_mul(w, 10, t10);
		t100 = sq_run_mul(t50, 50, t50);
		w    = sq_run_mul(t100, 100, t100);
		w    = sq_run_mul(w, 50, t50);
		return sq_run_mul(w, 5, z11);
	endfunction

	function automatic fe_t predict_result(input fop_t f);
		fe_t r;
		case (f.op)
			OP_MUL:  r = field_mul(f.a, f.b);
			OP_SQR:  r = field_mul(f.a, f.a);
			OP_INV:  r = field_inv(f.a);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic limb_t rand_limb();
		limb_t v;
		v = limb_t'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0:       v = '0;
			1:       v = '1;
			2:       v[LIMB_W-1] = 1'b0;
			default: ;
		endcase
		return v;
	endfunction

	function automatic fe_t rand_fe();
		fe_t v;
		for (int i = 0; i < NUM_LIMBS; i++) v[i] = rand_limb();
		return v;
	endfunction

	function automatic fe_t fill_fe(input limb_t l);
		fe_t v;
		for (int i = 0; i < NUM_LIMBS; i++) v[i] = l;
		return v;
	endfunction

	task automatic add_op(input logic [1:0] op, input fe_t a, input fe_t b);
		fop_t f;
		f.op = op;
		f.a  = a;
		f.b  = b;
		pending_ops.push_back(f);
	endtask

	// stimulus
	initial begin
		fe_t zero, ones, one, p_fe;
		int  n_inv;
		logic [1:0] op;
		zero = '0;
		ones = fill_fe('1);
		one  = '0;
		one[0] = limb_t'(1);
		p_fe = fill_fe(limb_t'(MASK51));
		p_fe[0] = limb_t'(MASK51 - 18);
		add_op(OP_MUL, zero, zero);
		add_op(OP_MUL, ones, ones);
		add_op(OP_MUL, one, ones);
		add_op(OP_MUL, ones, zero);
		add_op(OP_MUL, p_fe, rand_fe());
		add_op(OP_SQR, ones, zero);
		add_op(OP_SQR, zero, ones);
		add_op(OP_SQR, p_fe, zero);
		add_op(OP_INV, zero, zero);       // zero maps to zero
		add_op(OP_INV, p_fe, ones);       // p is zero as well
		add_op(OP_INV, ones, zero);
		add_op(OP_INV, one, zero);
		add_op(OP_NONE, ones, ones);
		add_op(OP_NONE, zero, zero);
		add_op(OP_MUL, rand_fe(), rand_fe());
		n_inv = 0;
		for (int k = 0; k < N_RAND; k++) begin
			op = 2'($urandom_range(0, 2));
			if (op == OP_INV || $urandom_range(0, 19) == 0) op = OP_NONE;
			if (n_inv < MAX_INV && $urandom_range(0, 44) == 0) op = OP_INV;
			if (op == OP_INV) n_inv++;
			add_op(op, rand_fe(), rand_fe());
		end
		total_ops = pending_ops.size();
	end

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: offer pending transactions with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			s_tuser   <= '0;
			cur_op    = '0;
			sent_ops  = 0;
			src_gap   = 0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				expected_prods.push_back(predict_result(cur_op));
				sent_ops++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending_ops.size() > 0) begin
					cur_op = pending_ops.pop_front();
					busy   = 1'b1;
					if (sent_ops < total_ops - QUIET_N && $urandom_range(0, 4) == 0)
						src_gap = $urandom_range(1, 11);
				end
			end
			s_tvalid <= busy;
			s_tdata  <= {cur_op.b, cur_op.a};
			s_tuser  <= cur_op.op;
		end
	end

	// monitor: check results, random backpressure and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		fe_t exp_r;
		fe_t got_r;
		if (!arst_n) begin
			m_tready       <= 1'b0;
			got_results    = 0;
			err_count      = 0;
			snk_gap        = 0;
			long_hold_done = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r = m_tdata[NUM_LIMBS*LIMB_W-1:0];
				if (expected_prods.size() == 0) begin
					$error("unexpected result transaction: %h", got_r);
					err_count++;
				end else begin
					exp_r = expected_prods.pop_front();
					for (int i = 0; i < NUM_LIMBS; i++)
						if (got_r[i] !== exp_r[i]) begin
							$error("r_limb%0d: expected %h, got %h", i, exp_r[i], got_r[i]);
							err_count++;
						end
				end
				got_results++;
			end
			if (!long_hold_done && got_results == 20) begin
				long_hold_done = 1'b1;
				snk_gap = 3000;
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (sent_ops < total_ops - QUIET_N && $urandom_range(0, 3) == 0) begin
				snk_gap = $urandom_range(1, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// end of run
	initial begin
		@(posedge arst_n);
		wait (total_ops > 0 && sent_ops == total_ops);
		wait (expected_prods.size() == 0);
		repeat (200) @(posedge clk);
		if (err_count == 0)
			$display("tb_curve25519_field_mul_sqr_inv: done, clean");
		else
			$display("tb_curve25519_field_mul_sqr_inv: done, errors");
		$finish;
	end

	// timeout
	initial begin
		#(20 * 3_000_000);
		$display("tb_curve25519_field_mul_sqr_inv: done, errors");
		$finish;
	end

endmodule
